// File: hw/rtl/bswg_pkg.sv
// Package for the B-spline window generator: beat types, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package bswg_pkg;

  localparam int MaxLog2SizeDefault = 12;
  localparam int SampleFracBitsDefault = 23;

  localparam logic OP_PREPARE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_UNPREPPED = 2'd2;

  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_LOG2  = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [11:0] sample_index;
  } in_beat_t;

  typedef struct packed {
    logic [23:0] sample_value;
    logic [31:0] norm_factor;
    logic [1:0]  status;
  } out_beat_t;

endpackage

// File: hw/rtl/bswg_mul.sv
// Shared 33x33 unsigned multiplier with a registered product.
// Depends on nothing; used by the sequencer in the top level.
`timescale 1ns / 1ps
module bswg_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [65:0] p
);
  // One product per cycle, registered before use.
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// File: hw/rtl/bspline_window_generator_core.sv
// B-spline window generator top level: sequencer around one shared multiplier.
// Depends on bswg_pkg and bswg_mul.
`timescale 1ns / 1ps
//
// Usage: write the order, log2 size and shift registers through cfg_we,
// cfg_index and cfg_wdata while idle; any write of a listed register drops the
// prepared factor. Raise in_start with an in_beat when in_busy is low; the
// beat is taken at that edge. Every beat gives exactly one result beat on
// out_beat, marked by out_strobe for a single cycle.
// A read beat (opcode 1) runs t, t*t, t*t*t, the numerator, a divide by three
// (whose result only order 3 uses) and the scale multiply. in_busy stays high
// until the result beat is out, so a new beat is not taken before that. A read
// refused for range or for a missing factor returns on the next cycle.
// A prepare beat (opcode 0) walks samples 1..N-1 through the same steps up to
// the divide, squares each sample into the energy sum, then finds the reciprocal
// root bit by bit from bit 31 down. Every step shares the single multiplier,
// which takes one product per cycle with a registered output.
// The receiver cannot stall, so results are never held back.
// Reset restores the register defaults and clears the factor and its valid flag.
//
module bspline_window_generator_core
  import bswg_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MaxLog2SizeDefault,
  parameter int SAMPLE_FRAC_BITS = SampleFracBitsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_start,
  output logic      in_busy,
  input  in_beat_t  in_beat,
  output logic      out_strobe,
  output out_beat_t out_beat,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int JW = MAX_LOG2_SIZE;
  localparam int NW = MAX_LOG2_SIZE + 1;
  localparam int XW = MAX_LOG2_SIZE + 18;
  localparam int RS = 32 - SAMPLE_FRAC_BITS;
  localparam int E2 = 48 + 2 * SAMPLE_FRAC_BITS;
  localparam logic [127:0] Thr = 128'd1 << E2;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_TT   = 19'h00002,
    S_SQ   = 19'h00004,
    S_W2   = 19'h00008,
    S_CU   = 19'h00010,
    S_W3   = 19'h00020,
    S_NUM  = 19'h00040,
    S_DV   = 19'h00080,
    S_RAW  = 19'h00100,
    S_SC   = 19'h00200,
    S_SM   = 19'h00400,
    S_SQE  = 19'h00800,
    S_ACC  = 19'h01000,
    S_RC   = 19'h02000,
    S_RQ   = 19'h04000,
    S_RP   = 19'h08000,
    S_RL   = 19'h10000,
    S_RD   = 19'h20000,
    S_DONE = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]    order_r;
  logic [3:0]    log2_r;
  logic [15:0]   shift_r;
  logic [31:0]   factor_r;
  logic          fvalid_r;
  logic          op_r;
  logic [JW-1:0] j_r;
  logic [31:0]   t_r, t2_r, t3_r;
  logic [1:0]    seg_r;
  logic [31:0]   numr_r;
  logic [31:0]   raw_r;
  logic [63:0]   acc_r;
  logic [31:0]   cand_r;
  logic [4:0]    bit_r;
  logic [63:0]   csq_r;
  logic [1:0]    pp_r;
  logic [127:0]  psum_r;
  logic [23:0]   smp_r;
  logic [1:0]    stat_r;

  logic [32:0] ma, mb;
  logic [65:0] mp;

  bswg_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // Effective window exponent, clamped to the supported range.
  logic [4:0] leff;
  always_comb begin
    if (log2_r < 4'd3) leff = 5'd3;
    else if (32'(log2_r) > 32'(MAX_LOG2_SIZE)) leff = 5'(MAX_LOG2_SIZE);
    else leff = 5'(log2_r);
  end

  logic [NW-1:0] nsize;
  logic          idx_big;
  logic          walk_done;
  assign nsize = NW'(1) << leff;
  assign idx_big = (32'(in_beat.sample_index) >= 32'(nsize));
  assign walk_done = ({1'b0, j_r} == nsize - NW'(1));

  // Segment and local coordinate from X = k*P (k small, a shift-add).
  logic [XW-1:0] pos, xk;
  logic [2:0]    kk;
  logic [4:0]    tsh;
  logic [33:0]   tfull;
  assign kk  = 3'(order_r) + 3'd1;
  assign pos = XW'({j_r, shift_r});
  assign xk  = (kk[0] ? pos : XW'(0)) + (kk[1] ? (pos << 1) : XW'(0))
             + (kk[2] ? (pos << 2) : XW'(0));
  assign tsh   = 5'd16 - leff;
  assign tfull = 34'(64'(xk) << tsh);

  // Numerator per order and segment, signed with room for 7*one.
  logic signed [37:0] num, one_s, ti, t2i, t3i;
  always_comb begin
    one_s = 38'sd1 <<< 32;
    ti  = $signed({6'd0, t_r});
    t2i = $signed({6'd0, t2_r});
    t3i = $signed({6'd0, t3_r});
    case (order_r)
      2'd0: num = one_s;
      2'd1: num = (seg_r == 2'd0) ? ti : one_s - ti;
      2'd2: begin
        if (seg_r == 2'd0) num = t2i;
        else if (seg_r == 2'd1) num = one_s + 38'sd2 * ti - 38'sd2 * t2i;
        else num = one_s - 38'sd2 * ti + t2i;
      end
      default: begin
        if (seg_r == 2'd0) num = t3i;
        else if (seg_r == 2'd1) num = one_s + 38'sd3 * ti + 38'sd3 * t2i - 38'sd3 * t3i;
        else if (seg_r == 2'd2) num = 38'sd4 * one_s - 38'sd6 * t2i + 38'sd3 * t3i;
        else num = one_s - 38'sd3 * ti + 38'sd3 * t2i - t3i;
      end
    endcase
  end

  // Clamp, add half the divisor and divide by 2^RS (orders 0, 1) or
  // 2^(RS+1) (orders 2, 3); order 3 still owes a divide by three.
  logic [37:0] numc, half, numsum;
  logic [31:0] numq;
  assign numc = num[37] ? 38'd0 : $unsigned(num);
  always_comb begin
    case (order_r)
      2'd2:    half = 38'd1 << RS;
      2'd3:    half = 38'd3 << RS;
      default: half = 38'd1 << (RS - 1);
    endcase
  end
  assign numsum = numc + half;
  assign numq = order_r[1] ? 32'(numsum >> (RS + 1)) : 32'(numsum >> RS);

  // Reciprocal root: candidate with the current bit set, and the decision.
  logic [31:0] cand_try, cand_new;
  assign cand_try = cand_r | (32'd1 << bit_r);
  assign cand_new = (psum_r <= Thr) ? cand_try : cand_r;

  // Partial products of cand^2 * E, each added at its weight.
  logic [1:0]   pprev;
  logic [6:0]   ppsh;
  logic [127:0] ppadd;
  assign pprev = (state_r == S_RL) ? 2'd3 : pp_r - 2'd1;
  assign ppsh  = (pprev == 2'd0) ? 7'd0 : ((pprev == 2'd3) ? 7'd64 : 7'd32);
  assign ppadd = 128'(mp[63:0]) << ppsh;

  // Saturating energy sum and rounded, saturated scaled sample.
  logic [63:0] accsum;
  logic        accov;
  logic [66:0] rnd;
  assign {accov, accsum} = 65'(acc_r) + 65'(mp[63:0]);
  assign rnd = 67'(mp) + 67'h800000;

  // Multiplier operand selection.
  always_comb begin
    ma = 33'd0; mb = 33'd0;
    case (state_r)
      S_SQ:  begin ma = {1'b0, t_r};    mb = {1'b0, t_r}; end
      S_CU:  begin ma = {1'b0, t2_r};   mb = {1'b0, t_r}; end
      S_DV:  begin ma = {1'b0, numr_r}; mb = 33'h0AAAAAAAB; end
      S_SC:  begin ma = {1'b0, raw_r};  mb = {1'b0, factor_r}; end
      S_SQE: begin ma = {1'b0, raw_r};  mb = {1'b0, raw_r}; end
      S_RC:  begin ma = {1'b0, cand_try}; mb = {1'b0, cand_try}; end
      S_RP: begin
        ma = {1'b0, pp_r[1] ? csq_r[63:32] : csq_r[31:0]};
        mb = {1'b0, pp_r[0] ? acc_r[63:32] : acc_r[31:0]};
      end
      default: ;
    endcase
  end

  // Main sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      order_r <= 2'd0; log2_r <= 4'd8; shift_r <= 16'd0;
      factor_r <= 32'd0; fvalid_r <= 1'b0; op_r <= 1'b0;
      j_r <= '0; t_r <= '0; t2_r <= '0; t3_r <= '0; seg_r <= 2'd0;
      numr_r <= '0; raw_r <= '0; acc_r <= '0;
      cand_r <= '0; bit_r <= 5'd31; csq_r <= '0; pp_r <= 2'd0; psum_r <= '0;
      smp_r <= 24'd0; stat_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ORDER: begin order_r <= cfg_wdata[1:0]; fvalid_r <= 1'b0; end
          REG_LOG2:  begin log2_r <= cfg_wdata[3:0]; fvalid_r <= 1'b0; end
          REG_SHIFT: begin shift_r <= cfg_wdata; fvalid_r <= 1'b0; end
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_start) begin
          op_r <= in_beat.opcode;
          acc_r <= 64'd0;
          smp_r <= 24'd0;
          if (in_beat.opcode == OP_PREPARE) begin
            j_r <= JW'(1);
            stat_r <= ST_OK;
          end else begin
            j_r <= JW'(in_beat.sample_index);
            if (!fvalid_r) stat_r <= ST_UNPREPPED;
            else if (idx_big) stat_r <= ST_RANGE;
            else stat_r <= ST_OK;
          end
        end
        S_TT: begin
          t_r <= tfull[31:0];
          seg_r <= tfull[33:32];
        end
        S_W2:  t2_r <= 32'((mp + 66'h80000000) >> 32);
        S_W3:  t3_r <= 32'((mp + 66'h80000000) >> 32);
        S_NUM: numr_r <= numq;
        S_RAW: raw_r <= (j_r == '0) ? 32'd0 : ((order_r == 2'd3) ? mp[64:33] : numr_r);
        S_SM:  smp_r <= (|rnd[66:48]) ? 24'hFFFFFF : rnd[47:24];
        S_ACC: begin
          acc_r <= accov ? 64'hFFFFFFFFFFFFFFFF : accsum;
          j_r <= j_r + JW'(1);
          if (walk_done) begin
            cand_r <= 32'd0;
            bit_r <= 5'd31;
          end
        end
        S_RQ: begin
          csq_r <= mp[63:0];
          psum_r <= '0;
          pp_r <= 2'd0;
        end
        S_RP: begin
          pp_r <= pp_r + 2'd1;
          if (pp_r != 2'd0) psum_r <= psum_r + ppadd;
        end
        S_RL: psum_r <= psum_r + ppadd;
        S_RD: begin
          cand_r <= cand_new;
          if (bit_r == 5'd0) begin
            factor_r <= cand_new;
            fvalid_r <= 1'b1;
          end else begin
            bit_r <= bit_r - 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_start) begin
        if (in_beat.opcode == OP_READ && (!fvalid_r || idx_big)) state_nxt = S_DONE;
        else state_nxt = S_TT;
      end
      S_TT:  state_nxt = S_SQ;
      S_SQ:  state_nxt = S_W2;
      S_W2:  state_nxt = S_CU;
      S_CU:  state_nxt = S_W3;
      S_W3:  state_nxt = S_NUM;
      S_NUM: state_nxt = S_DV;
      S_DV:  state_nxt = S_RAW;
      S_RAW: state_nxt = (op_r == OP_READ) ? S_SC : S_SQE;
      S_SC:  state_nxt = S_SM;
      S_SM:  state_nxt = S_DONE;
      S_SQE: state_nxt = S_ACC;
      S_ACC: state_nxt = walk_done ? S_RC : S_TT;
      S_RC:  state_nxt = S_RQ;
      S_RQ:  state_nxt = S_RP;
      S_RP:  state_nxt = (pp_r == 2'd3) ? S_RL : S_RP;
      S_RL:  state_nxt = S_RD;
      S_RD:  state_nxt = (bit_r == 5'd0) ? S_DONE : S_RC;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result beat and handshake outputs.
  always_comb begin
    out_beat.norm_factor  = factor_r;
    out_beat.sample_value = smp_r;
    out_beat.status       = stat_r;
  end

  assign in_busy    = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  // Assertions.
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held two cycles");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_start && !in_busy) |=> in_busy) else $error("start not taken");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_beat.status != ST_OK |-> out_beat.sample_value == 24'd0)
    else $error("refused read with nonzero sample");

endmodule
